// ===== src/ttf_pkg.sv =====
// shared widths and beat types for the triangle tangent frame unit
package ttf_pkg;

	localparam int VEC_W    = 16;
	localparam int DIFF_W   = VEC_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int NORM_TOP = 29;
	localparam int MAG_W    = NORM_TOP + 1;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUMSQ_W  = SQ_W + 2;
	localparam int ROOT_W   = SUMSQ_W / 2;

	typedef struct packed {
		logic signed [VEC_W-1:0] v0_x;
		logic signed [VEC_W-1:0] v0_y;
		logic signed [VEC_W-1:0] v0_z;
		logic signed [VEC_W-1:0] v1_x;
		logic signed [VEC_W-1:0] v1_y;
		logic signed [VEC_W-1:0] v1_z;
		logic signed [VEC_W-1:0] v2_x;
		logic signed [VEC_W-1:0] v2_y;
		logic signed [VEC_W-1:0] v2_z;
	} tri_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] norm_x;
		logic signed [VEC_W-1:0] norm_y;
		logic signed [VEC_W-1:0] norm_z;
		logic signed [VEC_W-1:0] tan_x;
		logic signed [VEC_W-1:0] tan_y;
		logic signed [VEC_W-1:0] tan_z;
		logic                    degenerate;
	} frame_t;

endpackage

// ===== src/ttf_if.sv =====
// valid/ready channel carrying one beat of type T
interface ttf_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ttf_front.sv =====
// edge differences, cross product, determinant and raw tangent pipeline
module ttf_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  ttf_pkg::tri_t                         in_tri,
	output logic                                  out_valid,
	output logic [2:0][ttf_pkg::CROSS_W-1:0]      cross_vec,
	output logic [2:0][ttf_pkg::CROSS_W-1:0]      traw_vec,
	output logic                                  det_zero
);
	import ttf_pkg::*;

	logic signed [VEC_W-1:0]   p0 [3];
	logic signed [VEC_W-1:0]   p1 [3];
	logic signed [VEC_W-1:0]   p2 [3];

	logic signed [DIFF_W-1:0]  a_s1 [3];
	logic signed [DIFF_W-1:0]  b_s1 [3];
	logic signed [DIFF_W-1:0]  e2_s1 [3];
	logic signed [PROD_W-1:0]  pr_s2 [10];
	logic signed [CROSS_W-1:0] cr_s3 [3];
	logic signed [CROSS_W-1:0] det_s3;
	logic signed [CROSS_W-1:0] tz_s3;
	logic [2:0][CROSS_W-1:0]   cr_s4;
	logic [2:0][CROSS_W-1:0]   tr_s4;
	logic                      dz_s4;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4;

	always_comb begin
		p0[0] = in_tri.v0_x; p0[1] = in_tri.v0_y; p0[2] = in_tri.v0_z;
		p1[0] = in_tri.v1_x; p1[1] = in_tri.v1_y; p1[2] = in_tri.v1_z;
		p2[0] = in_tri.v2_x; p2[1] = in_tri.v2_y; p2[2] = in_tri.v2_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				a_s1[j]  <= DIFF_W'(p1[j]) - DIFF_W'(p0[j]);
				b_s1[j]  <= DIFF_W'(p2[j]) - DIFF_W'(p1[j]);
				e2_s1[j] <= DIFF_W'(p2[j]) - DIFF_W'(p0[j]);
			end
			pr_s2[0] <= a_s1[1] * b_s1[2];
			pr_s2[1] <= a_s1[2] * b_s1[1];
			pr_s2[2] <= a_s1[2] * b_s1[0];
			pr_s2[3] <= a_s1[0] * b_s1[2];
			pr_s2[4] <= a_s1[0] * b_s1[1];
			pr_s2[5] <= a_s1[1] * b_s1[0];
			pr_s2[6] <= a_s1[0] * e2_s1[1];
			pr_s2[7] <= e2_s1[0] * a_s1[1];
			pr_s2[8] <= e2_s1[1] * a_s1[2];
			pr_s2[9] <= a_s1[1] * e2_s1[2];
			cr_s3[0] <= CROSS_W'(pr_s2[0]) - CROSS_W'(pr_s2[1]);
			cr_s3[1] <= CROSS_W'(pr_s2[2]) - CROSS_W'(pr_s2[3]);
			cr_s3[2] <= CROSS_W'(pr_s2[4]) - CROSS_W'(pr_s2[5]);
			det_s3   <= CROSS_W'(pr_s2[6]) - CROSS_W'(pr_s2[7]);
			tz_s3    <= CROSS_W'(pr_s2[8]) - CROSS_W'(pr_s2[9]);
			// raw tangent x equals the magnitude of the determinant, y cancels exactly
			for (int j = 0; j < 3; j++) cr_s4[j] <= cr_s3[j];
			tr_s4[0] <= det_s3[CROSS_W-1] ? -det_s3 : det_s3;
			tr_s4[1] <= '0;
			tr_s4[2] <= det_s3[CROSS_W-1] ? -tz_s3 : tz_s3;
			dz_s4    <= (det_s3 == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign cross_vec = cr_s4;
	assign traw_vec  = tr_s4;
	assign det_zero  = dz_s4;
endmodule

// ===== src/ttf_norm.sv =====
// pipelined vector normalize: range shift, bit-serial square root, bit-serial divides
module ttf_norm #(
	parameter int W      = 35,
	parameter int F      = 14,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][W-1:0]    in_vec,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [2:0][F+1:0]    out_vec,
	output logic                 out_zero,
	output logic [SIDE_W-1:0]    out_side
);
	import ttf_pkg::*;

	localparam int PW    = $clog2(W);
	localparam int EXT_W = W + NORM_TOP;
	localparam int TR_W  = SUMSQ_W + 2;
	localparam int NDV   = F + 1;
	localparam int DV_W  = F + ROOT_W;
	localparam int Q_W   = F + 1;
	localparam int O_W   = F + 2;

	function automatic logic [PW-1:0] lead_pos(input logic [W-1:0] v);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < W; i++) begin
			if (v[i]) p = PW'(i);
		end
		return p;
	endfunction

	// front stages
	logic [2:0][W-1:0]      mag_s1, mag_s2, mag_s3;
	logic [2:0]             neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [SIDE_W-1:0]      side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [W-1:0]           top_s2;
	logic [PW-1:0]          pos_s3;
	logic                   zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic [2:0][MAG_W-1:0]  m_s4, m_s5, m_s6;
	logic [2:0][SQ_W-1:0]   sq_s5;
	logic [SUMSQ_W-1:0]     sum_s6;
	logic [2:0][DV_W-1:0]   num_s7;
	logic [ROOT_W-1:0]      len_s7;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [2:0][O_W-1:0]    res_s8;
	logic                   zero_s8;
	logic [SIDE_W-1:0]      side_s8;
	logic [EXT_W-1:0]       ext [3];

	// square root stages
	logic [SUMSQ_W-1:0]     rt_rem_s [ROOT_W];
	logic [ROOT_W-1:0]      rt_root_s [ROOT_W];
	logic [2:0][MAG_W-1:0]  rt_m_s [ROOT_W];
	logic [2:0]             rt_neg_s [ROOT_W];
	logic                   rt_zero_s [ROOT_W];
	logic [SIDE_W-1:0]      rt_side_s [ROOT_W];
	logic                   rt_vld_s [ROOT_W];

	// divide stages
	logic [2:0][DV_W-1:0]   dv_rem_s [NDV];
	logic [2:0][Q_W-1:0]    dv_q_s [NDV];
	logic [ROOT_W-1:0]      dv_len_s [NDV];
	logic [2:0]             dv_neg_s [NDV];
	logic                   dv_zero_s [NDV];
	logic [SIDE_W-1:0]      dv_side_s [NDV];
	logic                   dv_vld_s [NDV];

	always_comb begin
		for (int i = 0; i < 3; i++) ext[i] = {mag_s3[i], {NORM_TOP{1'b0}}} >> pos_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= in_vec[i][W-1];
				mag_s1[i] <= in_vec[i][W-1] ? (~in_vec[i] + W'(1)) : in_vec[i];
			end
			side_s1 <= in_side;
			// largest magnitude
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			side_s2 <= side_s1;
			if (mag_s1[0] >= mag_s1[1] && mag_s1[0] >= mag_s1[2]) top_s2 <= mag_s1[0];
			else if (mag_s1[1] >= mag_s1[2]) top_s2 <= mag_s1[1];
			else top_s2 <= mag_s1[2];
			// leading one
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			side_s3 <= side_s2;
			pos_s3 <= lead_pos(top_s2);
			zero_s3 <= (top_s2 == '0);
			// bring the top into [2^29, 2^30)
			for (int i = 0; i < 3; i++) m_s4[i] <= ext[i][MAG_W-1:0];
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) sq_s5[i] <= m_s4[i] * m_s4[i];
			m_s5 <= m_s4;
			neg_s5 <= neg_s4;
			zero_s5 <= zero_s4;
			side_s5 <= side_s4;
			sum_s6 <= SUMSQ_W'(sq_s5[0]) + SUMSQ_W'(sq_s5[1]) + SUMSQ_W'(sq_s5[2]);
			m_s6 <= m_s5;
			neg_s6 <= neg_s5;
			zero_s6 <= zero_s5;
			side_s6 <= side_s5;
			// dividend with half the length for rounding
			len_s7 <= rt_root_s[ROOT_W-1];
			for (int i = 0; i < 3; i++) begin
				num_s7[i] <= (DV_W'(rt_m_s[ROOT_W-1][i]) << F)
					+ DV_W'(rt_root_s[ROOT_W-1] >> 1);
			end
			neg_s7 <= rt_neg_s[ROOT_W-1];
			zero_s7 <= rt_zero_s[ROOT_W-1];
			side_s7 <= rt_side_s[ROOT_W-1];
			// sign and zero vector
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[NDV-1]) res_s8[i] <= '0;
				else if (dv_neg_s[NDV-1][i]) res_s8[i] <= O_W'(0) - O_W'(dv_q_s[NDV-1][i]);
				else res_s8[i] <= O_W'(dv_q_s[NDV-1][i]);
			end
			zero_s8 <= dv_zero_s[NDV-1];
			side_s8 <= dv_side_s[NDV-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= rt_vld_s[ROOT_W-1];
			vld_s8 <= dv_vld_s[NDV-1];
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_rt
		localparam int B = ROOT_W - 1 - k;
		logic [SUMSQ_W-1:0]    rem_i;
		logic [ROOT_W-1:0]     root_i;
		logic [2:0][MAG_W-1:0] m_i;
		logic [2:0]            neg_i;
		logic                  zero_i;
		logic [SIDE_W-1:0]     side_i;
		logic                  vld_i;
		logic [TR_W-1:0]       trial;
		if (k == 0) begin : g_first
			assign rem_i  = sum_s6;
			assign root_i = '0;
			assign m_i    = m_s6;
			assign neg_i  = neg_s6;
			assign zero_i = zero_s6;
			assign side_i = side_s6;
			assign vld_i  = vld_s6;
		end else begin : g_next
			assign rem_i  = rt_rem_s[k-1];
			assign root_i = rt_root_s[k-1];
			assign m_i    = rt_m_s[k-1];
			assign neg_i  = rt_neg_s[k-1];
			assign zero_i = rt_zero_s[k-1];
			assign side_i = rt_side_s[k-1];
			assign vld_i  = rt_vld_s[k-1];
		end
		assign trial = (TR_W'(root_i) << (B + 1)) | (TR_W'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (TR_W'(rem_i) >= trial) begin
					rt_rem_s[k]  <= SUMSQ_W'(TR_W'(rem_i) - trial);
					rt_root_s[k] <= root_i | (ROOT_W'(1) << B);
				end else begin
					rt_rem_s[k]  <= rem_i;
					rt_root_s[k] <= root_i;
				end
				rt_m_s[k]    <= m_i;
				rt_neg_s[k]  <= neg_i;
				rt_zero_s[k] <= zero_i;
				rt_side_s[k] <= side_i;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_vld_s[k] <= 1'b0;
			else if (en) rt_vld_s[k] <= vld_i;
		end
	end

	// one quotient bit per stage, three lanes
	for (genvar j = 0; j < NDV; j++) begin : g_dv
		localparam int B = F - j;
		logic [2:0][DV_W-1:0] rem_i;
		logic [2:0][Q_W-1:0]  q_i;
		logic [ROOT_W-1:0]    len_i;
		logic [2:0]           neg_i;
		logic                 zero_i;
		logic [SIDE_W-1:0]    side_i;
		logic                 vld_i;
		logic [DV_W-1:0]      dsr;
		if (j == 0) begin : g_first
			assign rem_i  = num_s7;
			assign q_i    = '0;
			assign len_i  = len_s7;
			assign neg_i  = neg_s7;
			assign zero_i = zero_s7;
			assign side_i = side_s7;
			assign vld_i  = vld_s7;
		end else begin : g_next
			assign rem_i  = dv_rem_s[j-1];
			assign q_i    = dv_q_s[j-1];
			assign len_i  = dv_len_s[j-1];
			assign neg_i  = dv_neg_s[j-1];
			assign zero_i = dv_zero_s[j-1];
			assign side_i = dv_side_s[j-1];
			assign vld_i  = dv_vld_s[j-1];
		end
		assign dsr = DV_W'(len_i) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_i[i] >= dsr) begin
						dv_rem_s[j][i] <= rem_i[i] - dsr;
						dv_q_s[j][i]   <= q_i[i] | (Q_W'(1) << B);
					end else begin
						dv_rem_s[j][i] <= rem_i[i];
						dv_q_s[j][i]   <= q_i[i];
					end
				end
				dv_len_s[j]  <= len_i;
				dv_neg_s[j]  <= neg_i;
				dv_zero_s[j] <= zero_i;
				dv_side_s[j] <= side_i;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[j] <= 1'b0;
			else if (en) dv_vld_s[j] <= vld_i;
		end
	end

	assign out_valid = vld_s8;
	assign out_vec   = res_s8;
	assign out_zero  = zero_s8;
	assign out_side  = side_s8;
endmodule

// ===== src/ttf_gs.sv =====
// dot product, rounding and gram-schmidt subtraction pipeline
module ttf_gs #(
	parameter int F = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2:0][F+1:0]       nv_in,
	input  logic [2:0][F+1:0]       tv_in,
	input  logic                    flag_in,
	output logic                    out_valid,
	output logic [2:0][2*F+6:0]     gs_vec,
	output logic [2:0][F+1:0]       nv_out,
	output logic                    flag_out
);
	localparam int NW  = F + 2;
	localparam int P_W = 2 * NW;
	localparam int D_W = P_W + 2;
	localparam int R_W = F + 4;
	localparam int G_W = 2 * F + 7;

	logic signed [P_W-1:0]  pr_s1 [3];
	logic signed [D_W-1:0]  dot_s2;
	logic [D_W-1:0]         dmag;
	logic [D_W-1:0]         drnd;
	logic signed [R_W-1:0]  dr_s3;
	logic signed [G_W-1:0]  t_s4 [3];
	logic signed [G_W-1:0]  p_s4 [3];
	logic [2:0][G_W-1:0]    gs_s5;
	logic [2:0][NW-1:0]     nv_s1, nv_s2, nv_s3, nv_s4, nv_s5;
	logic [2:0][NW-1:0]     tv_s1, tv_s2, tv_s3;
	logic                   fl_s1, fl_s2, fl_s3, fl_s4, fl_s5;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// half away from zero on the magnitude
	always_comb begin
		dmag = dot_s2[D_W-1] ? D_W'(-dot_s2) : D_W'(dot_s2);
		drnd = (dmag + (D_W'(1) << (F - 1))) >> F;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) pr_s1[i] <= $signed(nv_in[i]) * $signed(tv_in[i]);
			nv_s1 <= nv_in;
			tv_s1 <= tv_in;
			fl_s1 <= flag_in;
			dot_s2 <= D_W'(pr_s1[0]) + D_W'(pr_s1[1]) + D_W'(pr_s1[2]);
			nv_s2 <= nv_s1;
			tv_s2 <= tv_s1;
			fl_s2 <= fl_s1;
			dr_s3 <= dot_s2[D_W-1] ? -R_W'(drnd) : R_W'(drnd);
			nv_s3 <= nv_s2;
			tv_s3 <= tv_s2;
			fl_s3 <= fl_s2;
			for (int i = 0; i < 3; i++) begin
				t_s4[i] <= G_W'($signed(tv_s3[i])) <<< F;
				p_s4[i] <= $signed(nv_s3[i]) * dr_s3;
			end
			nv_s4 <= nv_s3;
			fl_s4 <= fl_s3;
			for (int i = 0; i < 3; i++) gs_s5[i] <= t_s4[i] - p_s4[i];
			nv_s5 <= nv_s4;
			fl_s5 <= fl_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_valid = vld_s5;
	assign gs_vec    = gs_s5;
	assign nv_out    = nv_s5;
	assign flag_out  = fl_s5;
endmodule

// ===== src/triangle_tangent_frame_unit.sv =====
// top level: triangle in, unit face normal and orthogonalized unit tangent out
//
//   channel     dir   beat       contents
//   tri_in      in    tri_t      three vertices, signed Q2.14 per coordinate
//   frame_out   out   frame_t    unit normal, unit tangent, degenerate flag
//
// one triangle per cycle sustained while frame_out is not stalled; the pipeline
// depth comes mostly from the two bit-serial square roots and the two
// bit-serial divide chains on its path through the normalize units
// reset clears the valid bits only; payload registers are not reset
// a stall on frame_out freezes the whole pipeline with tri_in.ready, so no
// beat is lost or repeated; tri_in.ready follows frame_out.ready combinationally
// while the output register holds a beat
module triangle_tangent_frame_unit #(
	parameter int FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	ttf_if.sink       tri_in,
	ttf_if.source     frame_out
);
	import ttf_pkg::*;

	localparam int NW = FRAC_BITS + 2;
	localparam int GW = 2 * FRAC_BITS + 7;
	localparam int XW = (NW > VEC_W) ? NW : VEC_W;
	localparam int SW = 3 * NW + 1;

	// global advance: move when the output slot is empty or being taken
	logic en;

	logic                      fr_valid;
	logic [2:0][CROSS_W-1:0]   fr_cross;
	logic [2:0][CROSS_W-1:0]   fr_traw;
	logic                      fr_dz;

	logic                      n_valid, n_zero;
	logic [2:0][NW-1:0]        n_vec;
	logic [0:0]                n_side;
	logic                      t_valid, t_zero;
	logic [2:0][NW-1:0]        t_vec;
	logic [0:0]                t_side;

	logic                      g_valid, g_flag;
	logic [2:0][GW-1:0]        g_vec;
	logic [2:0][NW-1:0]        g_nv;

	logic                      f_valid, f_zero, f_degen;
	logic [2:0][NW-1:0]        f_vec;
	logic [SW-1:0]             f_side;
	logic [2:0][NW-1:0]        f_nv;
	logic signed [XW-1:0]      nx [3];
	logic signed [XW-1:0]      tx [3];

	logic                      out_valid_q;
	frame_t                    frame_q;

	assign en             = !out_valid_q || frame_out.ready;
	assign tri_in.ready   = en;
	assign frame_out.valid = out_valid_q;
	assign frame_out.data  = frame_q;

	// edges, cross product, determinant, raw tangent
	ttf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tri_in.valid && en),
		.in_tri    (tri_in.data),
		.out_valid (fr_valid),
		.cross_vec (fr_cross),
		.traw_vec  (fr_traw),
		.det_zero  (fr_dz)
	);

	// face normal and raw tangent normalized side by side
	ttf_norm #(.W(CROSS_W), .F(FRAC_BITS), .SIDE_W(1)) u_norm_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_vec    (fr_cross),
		.in_side   (fr_dz),
		.out_valid (n_valid),
		.out_vec   (n_vec),
		.out_zero  (n_zero),
		.out_side  (n_side)
	);

	ttf_norm #(.W(CROSS_W), .F(FRAC_BITS), .SIDE_W(1)) u_norm_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_vec    (fr_traw),
		.in_side   (fr_dz),
		.out_valid (t_valid),
		.out_vec   (t_vec),
		.out_zero  (t_zero),
		.out_side  (t_side)
	);

	// t*2^F - n*round(n.t)
	ttf_gs #(.F(FRAC_BITS)) u_gs (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n_valid),
		.nv_in     (n_vec),
		.tv_in     (t_vec),
		.flag_in   (n_side[0] | t_side[0] | n_zero | t_zero),
		.out_valid (g_valid),
		.gs_vec    (g_vec),
		.nv_out    (g_nv),
		.flag_out  (g_flag)
	);

	// final normalize carries the normal and the flag alongside
	ttf_norm #(.W(GW), .F(FRAC_BITS), .SIDE_W(SW)) u_norm_g (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (g_valid),
		.in_vec    (g_vec),
		.in_side   ({g_flag, g_nv}),
		.out_valid (f_valid),
		.out_vec   (f_vec),
		.out_zero  (f_zero),
		.out_side  (f_side)
	);

	// sign-extend before trimming so narrow formats keep their sign
	always_comb begin
		f_nv    = f_side[SW-2:0];
		f_degen = f_zero | f_side[SW-1];
		for (int i = 0; i < 3; i++) begin
			nx[i] = XW'($signed(f_nv[i]));
			tx[i] = XW'($signed(f_vec[i]));
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en && f_valid) begin
			if (f_degen) begin
				frame_q.norm_x     <= '0;
				frame_q.norm_y     <= '0;
				frame_q.norm_z     <= '0;
				frame_q.tan_x      <= '0;
				frame_q.tan_y      <= '0;
				frame_q.tan_z      <= '0;
				frame_q.degenerate <= 1'b1;
			end else begin
				frame_q.norm_x     <= nx[0][VEC_W-1:0];
				frame_q.norm_y     <= nx[1][VEC_W-1:0];
				frame_q.norm_z     <= nx[2][VEC_W-1:0];
				frame_q.tan_x      <= tx[0][VEC_W-1:0];
				frame_q.tan_y      <= tx[1][VEC_W-1:0];
				frame_q.tan_z      <= tx[2][VEC_W-1:0];
				frame_q.degenerate <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= f_valid;
		end
	end

`ifndef SYNTH
	// the two parallel normalize units must stay in lockstep
	a_norm_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		n_valid == t_valid)
		else $error("normal and tangent normalize units out of step");

	a_side_match: assert property (@(posedge clk) disable iff (!arst_n)
		n_valid |-> n_side == t_side)
		else $error("determinant flag differs between normalize units");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_q.degenerate |->
		frame_q.norm_x == '0 && frame_q.norm_y == '0 && frame_q.norm_z == '0 &&
		frame_q.tan_x == '0 && frame_q.tan_y == '0 && frame_q.tan_z == '0)
		else $error("degenerate beat with nonzero vectors");
`endif
endmodule

// ===== sim/tb_triangle_tangent_frame_unit.sv =====
// self-checking testbench for the triangle tangent frame unit
module tb_triangle_tangent_frame_unit;
	import ttf_pkg::*;

	localparam int FRAC = 14;
	localparam int LATENCY = 2 * FRAC + 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ttf_if #(.T(tri_t))   tri_ch ();
	ttf_if #(.T(frame_t)) frame_ch ();

	triangle_tangent_frame_unit #(.FRAC_BITS(FRAC)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_in    (tri_ch.sink),
		.frame_out (frame_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tri_t   pending_tris[$];
	frame_t frames_due[$];
	int     err_count = 0;
	bit     gen_done = 1'b0;
	bit     hold_tx = 1'b0;
	bit     tx_taken = 1'b0;
	int     tx_gap = 0;
	int     rx_gap = 0;

	// gap length: mostly zero or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 60);
	endfunction

	// scale a vector to unit length with FRAC fraction bits
	function automatic bit unit_len(input longint vin[3], output longint vout[3]);
		longint unsigned m[3];
		longint unsigned top, sq, root, rem, bitv, q;
		bit neg[3];
		top = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = vin[i] < 0;
			m[i] = neg[i] ? -vin[i] : vin[i];
			if (m[i] > top)
				top = m[i];
		end
		if (top == 0) begin
			vout = '{0, 0, 0};
			return 1'b0;
		end
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sq += m[i] * m[i];
		// digit-by-digit integer square root
		rem = sq;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC) + (root >> 1)) / root;
			vout[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	// expected frame of one triangle
	function automatic frame_t tangent_frame(input tri_t t);
		longint p0[3], p1[3], p2[3], a[3], b[3], e2[3];
		longint cr[3], nv[3], tr[3], tv[3], gs[3], tn[3];
		longint det, d, dm;
		bit ok;
		frame_t f;
		p0 = '{t.v0_x, t.v0_y, t.v0_z};
		p1 = '{t.v1_x, t.v1_y, t.v1_z};
		p2 = '{t.v2_x, t.v2_y, t.v2_z};
		for (int j = 0; j < 3; j++) begin
			a[j] = p1[j] - p0[j];
			b[j] = p2[j] - p1[j];
			e2[j] = p2[j] - p0[j];
		end
		cr[0] = a[1] * b[2] - a[2] * b[1];
		cr[1] = a[2] * b[0] - a[0] * b[2];
		cr[2] = a[0] * b[1] - a[1] * b[0];
		ok = unit_len(cr, nv);
		det = a[0] * e2[1] - e2[0] * a[1];
		if (det == 0)
			ok = 1'b0;
		if (ok) begin
			for (int j = 0; j < 3; j++) begin
				tr[j] = e2[1] * a[j] - a[1] * e2[j];
				if (det < 0)
					tr[j] = -tr[j];
			end
			ok = unit_len(tr, tv);
		end
		if (ok) begin
			d = nv[0] * tv[0] + nv[1] * tv[1] + nv[2] * tv[2];
			dm = d < 0 ? -d : d;
			dm = (dm + (64'd1 << (FRAC - 1))) >> FRAC;
			if (d < 0)
				dm = -dm;
			for (int j = 0; j < 3; j++)
				gs[j] = tv[j] * (64'sd1 <<< FRAC) - nv[j] * dm;
			ok = unit_len(gs, tn);
		end
		f = '0;
		if (!ok) begin
			f.degenerate = 1'b1;
		end else begin
			f.norm_x = nv[0][15:0];
			f.norm_y = nv[1][15:0];
			f.norm_z = nv[2][15:0];
			f.tan_x = tn[0][15:0];
			f.tan_y = tn[1][15:0];
			f.tan_z = tn[2][15:0];
		end
		return f;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// record each accepted triangle beat at the rising edge
	always @(posedge clk) begin
		if (arst_n && tri_ch.valid && tri_ch.ready) begin
			frames_due.push_back(tangent_frame(tri_ch.data));
			void'(pending_tris.pop_front());
			tx_gap = pick_gap();
			tx_taken = 1'b1;
		end
	end

	// driver: new beat presented at the falling edge, a waiting beat is held
	always @(negedge clk) begin
		if (arst_n) begin
			if (tx_taken || !tri_ch.valid) begin
				tx_taken = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
					tri_ch.valid <= 1'b0;
				end else if (pending_tris.size() > 0 && !hold_tx) begin
					tri_ch.valid <= 1'b1;
					tri_ch.data <= pending_tris[0];
				end else begin
					tri_ch.valid <= 1'b0;
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	// monitor: compare each accepted frame against the oldest expectation
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (frames_due.size() == 0) begin
				$display("unexpected frame beat at %0t", $realtime);
				err_count++;
			end else begin
				want = frames_due.pop_front();
				if (frame_ch.data.norm_x !== want.norm_x)
					report("norm_x", frame_ch.data.norm_x, want.norm_x);
				if (frame_ch.data.norm_y !== want.norm_y)
					report("norm_y", frame_ch.data.norm_y, want.norm_y);
				if (frame_ch.data.norm_z !== want.norm_z)
					report("norm_z", frame_ch.data.norm_z, want.norm_z);
				if (frame_ch.data.tan_x !== want.tan_x)
					report("tan_x", frame_ch.data.tan_x, want.tan_x);
				if (frame_ch.data.tan_y !== want.tan_y)
					report("tan_y", frame_ch.data.tan_y, want.tan_y);
				if (frame_ch.data.tan_z !== want.tan_z)
					report("tan_z", frame_ch.data.tan_z, want.tan_z);
				if (frame_ch.data.degenerate !== want.degenerate)
					report("degenerate", frame_ch.data.degenerate, want.degenerate);
			end
		end
	end

	function automatic tri_t mk_tri(input int c[9]);
		tri_t t;
		t = {c[0][15:0], c[1][15:0], c[2][15:0], c[3][15:0], c[4][15:0],
			c[5][15:0], c[6][15:0], c[7][15:0], c[8][15:0]};
		return t;
	endfunction

	// random triangle: local, zero-det, repeated vertex or fully random
	function automatic tri_t rand_tri();
		tri_t t;
		int r, k;
		r = $urandom_range(0, 9);
		t = tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if (r < 6) begin
			// small local triangle around a random point
			k = $urandom_range(1, 12);
			t.v0_x = 16'($urandom_range(0, 32767) - 16384);
			t.v0_y = 16'($urandom_range(0, 32767) - 16384);
			t.v0_z = 16'($urandom_range(0, 32767) - 16384);
			t.v1_x = t.v0_x + 16'($signed($urandom) >>> (20 + k));
			t.v1_y = t.v0_y + 16'($signed($urandom) >>> (20 + k));
			t.v1_z = t.v0_z + 16'($signed($urandom) >>> (20 + k));
			t.v2_x = t.v0_x + 16'($signed($urandom) >>> (20 + k));
			t.v2_y = t.v0_y + 16'($signed($urandom) >>> (20 + k));
			t.v2_z = t.v0_z + 16'($signed($urandom) >>> (20 + k));
		end else if (r == 6) begin
			// collinear in x/y: zero determinant
			t.v1_x = t.v0_x;
			t.v2_x = t.v0_x;
		end else if (r == 7) begin
			// repeated vertex
			t.v2_x = t.v1_x;
			t.v2_y = t.v1_y;
			t.v2_z = t.v1_z;
		end
		return t;
	endfunction

	initial begin
		int hold_at;
		tri_ch.valid = 1'b0;
		tri_ch.data = '0;
		frame_ch.ready = 1'b0;
		// directed: extremes, flat triangles, tangent along normal
		pending_tris.push_back(mk_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		pending_tris.push_back(mk_tri('{-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768}));
		pending_tris.push_back(mk_tri('{32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767}));
		pending_tris.push_back(mk_tri('{-32768, -32768, 32767, 32767, 32767, -32768,
			32767, -32768, 32767}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 16384, 0, 0, 0, 16384, 0}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 0, 16384, 0, 16384, 0, 0}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 16384, 16384, 0, 8192, 8192, 0}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 0, 0, 16384, 0, 0, -16384}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 0, 16384, 0, 0, 0, 16384}));
		pending_tris.push_back(mk_tri('{0, 0, 0, 16384, 0, 16384, 0, 16384, 16384}));
		pending_tris.push_back(mk_tri('{-1, -1, -1, 0, -1, -1, -1, 0, -1}));
		pending_tris.push_back(mk_tri('{5, 7, 100, 9, 3, -20, 1, 1, 1}));
		pending_tris.push_back(mk_tri('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767}));
		pending_tris.push_back(mk_tri('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
		for (int i = 0; i < 1850; i++)
			pending_tris.push_back(rand_tri());
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// pause the sender once until the pipeline has drained
		hold_at = pending_tris.size() / 2;
		wait (pending_tris.size() <= hold_at);
		hold_tx = 1'b1;
		wait (frames_due.size() == 0 && !tri_ch.valid);
		hold_tx = 1'b0;
		wait (pending_tris.size() == 0);
		gen_done = 1'b1;
	end

	initial begin
		wait (gen_done);
		@(posedge clk);
		wait (frames_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (err_count == 0)
			$display("tb_triangle_tangent_frame_unit: clean");
		else
			$display("tb_triangle_tangent_frame_unit: errors");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb_triangle_tangent_frame_unit: errors");
		$finish;
	end

endmodule
